/* rtl/core/baf_pkg.sv */
package baf_pkg;

    localparam int CW = 24;
    localparam int TOL_W = 48;
    localparam int BUD_W = 7;
    localparam int STACK_DEPTH = 7;
    localparam int SP_W = 3;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_EVAL  = 6'b000010,
        ST_TEST  = 6'b000100,
        ST_EMIT  = 6'b001000,
        ST_SPLIT = 6'b010000,
        ST_POP   = 6'b100000
    } state_t;

    typedef struct packed {
        logic load;
        logic eval_start;
        logic split;
        logic pop;
        logic emit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic eval_done;
        logic flat;
        logic stack_empty;
    } ctrl_sts_t;

endpackage

/* rtl/core/baf_near.sv */
module baf_near (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            start,
    input  logic signed [baf_pkg::CW-1:0]   px,
    input  logic signed [baf_pkg::CW-1:0]   py,
    input  logic signed [baf_pkg::CW-1:0]   ax,
    input  logic signed [baf_pkg::CW-1:0]   ay,
    input  logic signed [baf_pkg::CW-1:0]   bx,
    input  logic signed [baf_pkg::CW-1:0]   by,
    input  logic [baf_pkg::TOL_W-1:0]       tol,
    output logic                            done,
    output logic                            near
);
    import baf_pkg::*;

    // Stage 1: differences. Stage 2: products. Stage 3: sums. Stage 4: magnitude
    // and select. Stage 5: partial products. Stage 6: partial sums. Stage 7: compare.
    logic [6:0] vld_reg;
    logic signed [CW:0] ux_reg, uy_reg, vx_reg, vy_reg, wx_reg, wy_reg;
    logic signed [2*CW+1:0] uxvx_reg, uyvy_reg, uxux_reg, uyuy_reg, uxvy_reg, uyvx_reg;
    logic signed [2*CW+1:0] vxvx_reg, vyvy_reg, wxwx_reg, wywy_reg;
    logic signed [2*CW+2:0] dot_reg, len_reg, det_reg, dv_reg, dw_reg;
    logic [2*CW+2:0] m_reg, lenp_reg;
    logic [2*CW+3:0] mhh_reg, mhl_reg;
    logic [2*CW+1:0] mll_reg;
    logic [TOL_W/2+CW+1:0] thh_reg, thl_reg, tlh_reg, tll_reg;
    logic [4*CW+5:0] sq_reg;
    logic [TOL_W+2*CW+2:0] rhs_reg;
    logic [1:0] sel_reg, sel2_reg, sel3_reg;
    logic [2*CW+2:0] dist_reg, dist2_reg, dist3_reg;
    logic [TOL_W-1:0] tol_reg;
    logic near_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= {vld_reg[5:0], start};
        end
    end

    always_ff @(posedge aclk) begin
        ux_reg <= (CW+1)'(bx) - (CW+1)'(ax);
        uy_reg <= (CW+1)'(by) - (CW+1)'(ay);
        vx_reg <= (CW+1)'(px) - (CW+1)'(ax);
        vy_reg <= (CW+1)'(py) - (CW+1)'(ay);
        wx_reg <= (CW+1)'(px) - (CW+1)'(bx);
        wy_reg <= (CW+1)'(py) - (CW+1)'(by);
        tol_reg <= tol;
        uxvx_reg <= ux_reg * vx_reg;
        uyvy_reg <= uy_reg * vy_reg;
        uxux_reg <= ux_reg * ux_reg;
        uyuy_reg <= uy_reg * uy_reg;
        uxvy_reg <= ux_reg * vy_reg;
        uyvx_reg <= uy_reg * vx_reg;
        vxvx_reg <= vx_reg * vx_reg;
        vyvy_reg <= vy_reg * vy_reg;
        wxwx_reg <= wx_reg * wx_reg;
        wywy_reg <= wy_reg * wy_reg;
        dot_reg <= (2*CW+3)'(uxvx_reg) + (2*CW+3)'(uyvy_reg);
        len_reg <= (2*CW+3)'(uxux_reg) + (2*CW+3)'(uyuy_reg);
        det_reg <= (2*CW+3)'(uxvy_reg) - (2*CW+3)'(uyvx_reg);
        dv_reg  <= (2*CW+3)'(vxvx_reg) + (2*CW+3)'(vyvy_reg);
        dw_reg  <= (2*CW+3)'(wxwx_reg) + (2*CW+3)'(wywy_reg);
        m_reg   <= det_reg[2*CW+2] ? (2*CW+3)'(0) - det_reg : det_reg;
        lenp_reg <= $unsigned(len_reg);
        if (dot_reg <= 0) begin
            sel_reg <= 2'd0;
        end else if (dot_reg > len_reg) begin
            sel_reg <= 2'd1;
        end else begin
            sel_reg <= 2'd2;
        end
        dist_reg <= (dot_reg <= 0) ? dv_reg : dw_reg;
        // split operands into halves to keep each multiplier narrow
        mhh_reg <= (2*CW+4)'(m_reg[2*CW+2:CW+1]) * (2*CW+4)'(m_reg[2*CW+2:CW+1]);
        mhl_reg <= (2*CW+4)'(m_reg[2*CW+2:CW+1]) * (2*CW+4)'(m_reg[CW:0]);
        mll_reg <= (2*CW+2)'(m_reg[CW:0]) * (2*CW+2)'(m_reg[CW:0]);
        thh_reg <= (TOL_W/2+CW+2)'(tol_reg[TOL_W-1:TOL_W/2])
                   * (TOL_W/2+CW+2)'(lenp_reg[2*CW+2:CW+1]);
        thl_reg <= (TOL_W/2+CW+2)'(tol_reg[TOL_W-1:TOL_W/2])
                   * (TOL_W/2+CW+2)'(lenp_reg[CW:0]);
        tlh_reg <= (TOL_W/2+CW+2)'(tol_reg[TOL_W/2-1:0])
                   * (TOL_W/2+CW+2)'(lenp_reg[2*CW+2:CW+1]);
        tll_reg <= (TOL_W/2+CW+2)'(tol_reg[TOL_W/2-1:0])
                   * (TOL_W/2+CW+2)'(lenp_reg[CW:0]);
        sel2_reg <= sel_reg;
        dist2_reg <= dist_reg;
        sq_reg  <= ((4*CW+6)'(mhh_reg) << (2*CW+2)) + ((4*CW+6)'(mhl_reg) << (CW+2))
                   + (4*CW+6)'(mll_reg);
        rhs_reg <= ((TOL_W+2*CW+3)'(thh_reg) << (TOL_W/2+CW+1))
                   + ((TOL_W+2*CW+3)'(thl_reg) << (TOL_W/2))
                   + ((TOL_W+2*CW+3)'(tlh_reg) << (CW+1))
                   + (TOL_W+2*CW+3)'(tll_reg);
        sel3_reg <= sel2_reg;
        dist3_reg <= dist2_reg;
        if (sel3_reg == 2'd2) begin
            near_reg <= sq_reg < (4*CW+6)'(rhs_reg);
        end else begin
            near_reg <= (TOL_W+2*CW+3)'(dist3_reg) < (TOL_W+2*CW+3)'(tol_reg);
        end
    end

    assign done = vld_reg[6];
    assign near = near_reg;

endmodule

/* rtl/core/baf_datapath.sv */
module baf_datapath #(
    parameter int MAX_POINTS = 64
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  baf_pkg::ctrl_cmd_t            cmd,
    output baf_pkg::ctrl_sts_t            sts,
    input  logic [baf_pkg::TOL_W-1:0]     tol,
    input  logic                          in_kind,
    input  logic [8*baf_pkg::CW-1:0]      in_pts,
    input  logic [baf_pkg::BUD_W-1:0]     in_budget,
    output logic signed [baf_pkg::CW-1:0] end_x,
    output logic signed [baf_pkg::CW-1:0] end_y
);
    import baf_pkg::*;

    logic signed [CW-1:0] pt_reg [8];
    logic [BUD_W-1:0] bud_reg;
    logic cubic_reg;
    logic [SP_W-1:0] sp_reg;
    logic signed [CW-1:0] stk_pt [STACK_DEPTH][8];
    logic [BUD_W-1:0] stk_bud [STACK_DEPTH];
    logic second_reg, near1_reg, flat_reg, done_reg;
    logic signed [CW-1:0] lft [8];
    logic signed [CW-1:0] rgt [8];
    logic n_start, n_done, n_near;
    logic signed [CW-1:0] npx, npy, nbx, nby;
    logic [SP_W-1:0] sp_dec;

    function automatic logic signed [CW-1:0] avg(input logic signed [CW-1:0] a,
                                                 input logic signed [CW-1:0] b);
        logic signed [CW:0] s;
        s = (CW+1)'(a) + (CW+1)'(b);
        return s[CW:1];
    endfunction

    always_comb begin
        logic signed [CW-1:0] q0, q1, q2, r0, r1, s;
        for (int c = 0; c < 2; c++) begin
            q0 = avg(pt_reg[c], pt_reg[2+c]);
            q1 = avg(pt_reg[2+c], pt_reg[4+c]);
            q2 = avg(pt_reg[4+c], pt_reg[6+c]);
            r0 = avg(q0, q1);
            r1 = avg(q1, q2);
            s  = avg(r0, r1);
            lft[c] = pt_reg[c];
            lft[2+c] = q0;
            rgt[6+c] = '0;
            lft[6+c] = '0;
            if (cubic_reg) begin
                lft[4+c] = r0; lft[6+c] = s;
                rgt[c] = s; rgt[2+c] = r1; rgt[4+c] = q2; rgt[6+c] = pt_reg[6+c];
            end else begin
                lft[4+c] = r0;
                rgt[c] = r0; rgt[2+c] = q1; rgt[4+c] = pt_reg[4+c];
            end
        end
    end

    assign sp_dec = (sp_reg == '0) ? SP_W'(STACK_DEPTH-1) : sp_reg - 1'b1;
    assign end_x = cubic_reg ? pt_reg[6] : pt_reg[4];
    assign end_y = cubic_reg ? pt_reg[7] : pt_reg[5];
    // second test of a cubic starts on the first test's done, if the first test found it near
    assign npx = n_done ? pt_reg[4] : pt_reg[2];
    assign npy = n_done ? pt_reg[5] : pt_reg[3];
    assign nbx = end_x;
    assign nby = end_y;
    assign n_start = cmd.eval_start && bud_reg >= BUD_W'(2)
                     || (n_done && !second_reg && cubic_reg && n_near);

    baf_near u_near (
        .aclk(aclk), .aresetn(aresetn), .start(n_start),
        .px(npx), .py(npy), .ax(pt_reg[0]), .ay(pt_reg[1]), .bx(nbx), .by(nby),
        .tol(tol), .done(n_done), .near(n_near)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sp_reg <= '0;
            done_reg <= 1'b0;
            second_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (cmd.eval_start) begin
                second_reg <= 1'b0;
                if (bud_reg < BUD_W'(2)) begin
                    done_reg <= 1'b1;
                    flat_reg <= 1'b1;
                end
            end else if (n_done) begin
                if (!second_reg && cubic_reg && n_near) begin
                    second_reg <= 1'b1;
                end else begin
                    done_reg <= 1'b1;
                    flat_reg <= n_near;
                end
            end
            if (cmd.load) begin
                sp_reg <= '0;
                cubic_reg <= in_kind;
                bud_reg <= (in_budget > BUD_W'(MAX_POINTS)) ? BUD_W'(MAX_POINTS) : in_budget;
                for (int i = 0; i < 8; i++) pt_reg[i] <= in_pts[i*CW +: CW];
            end else if (cmd.split) begin
                for (int i = 0; i < 8; i++) begin
                    stk_pt[sp_reg][i] <= rgt[i];
                    pt_reg[i] <= lft[i];
                end
                stk_bud[sp_reg] <= bud_reg >> 1;
                bud_reg <= bud_reg >> 1;
                sp_reg <= (sp_reg == SP_W'(STACK_DEPTH-1)) ? '0 : sp_reg + 1'b1;
            end else if (cmd.pop) begin
                for (int i = 0; i < 8; i++) pt_reg[i] <= stk_pt[sp_dec][i];
                bud_reg <= stk_bud[sp_dec];
                sp_reg <= sp_dec;
            end
        end
    end

    assign sts.eval_done = done_reg;
    assign sts.flat = flat_reg;
    assign sts.stack_empty = (sp_reg == '0);

endmodule

/* rtl/core/baf_ctrl.sv */
module baf_ctrl #(
    parameter int MAX_POINTS = 64
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic               m_tlast,
    output baf_pkg::ctrl_cmd_t cmd,
    input  baf_pkg::ctrl_sts_t sts
);
    import baf_pkg::*;

    state_t state_reg, state_next;
    logic [BUD_W-1:0] cnt_reg, cnt_next;
    logic last_reg, last_next;

    always_comb begin
        state_next = state_reg;
        cnt_next = cnt_reg;
        last_next = last_reg;
        cmd = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load = 1'b1;
                    cnt_next = '0;
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL: begin
                cmd.eval_start = 1'b1;
                state_next = ST_TEST;
            end
            ST_TEST: begin
                if (sts.eval_done) begin
                    if (sts.flat) begin
                        cnt_next = cnt_reg + 1'b1;
                        last_next = sts.stack_empty || (cnt_reg + 1'b1 >= BUD_W'(MAX_POINTS));
                        state_next = ST_EMIT;
                    end else begin
                        state_next = ST_SPLIT;
                    end
                end
            end
            ST_SPLIT: begin
                cmd.split = 1'b1;
                state_next = ST_EVAL;
            end
            ST_EMIT: begin
                if (m_tready) begin
                    state_next = last_reg ? ST_IDLE : ST_POP;
                end
            end
            ST_POP: begin
                cmd.pop = 1'b1;
                state_next = ST_EVAL;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg <= '0;
            last_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg <= cnt_next;
            last_reg <= last_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = (state_reg == ST_EMIT);
    assign m_tlast = last_reg;

`ifndef ASSERT_OFF
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |-> !s_tready) else $error("accept while busy");
    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= BUD_W'(MAX_POINTS)) else $error("point count overflow");
    a_emit_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> m_tvalid) else $error("beat dropped");
`endif

endmodule

/* rtl/core/bezier_adaptive_flatten_top.sv */
// Adaptive de Casteljau flattener. One beat in is a quadratic or cubic curve with a
// point budget; out come the end points of its flat pieces, tlast on the final one.
// One curve at a time: each distance test runs through the pipelined unit, a subdivision
// node runs one test, or two when a cubic tests both control points, and a leaf with a
// budget below 2 skips the test. The shared distance pipeline sets how long a curve
// takes before output stalls. Tolerance may be written only while idle.
module bezier_adaptive_flatten_top #(
    parameter int MAX_POINTS = 64
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [47:0]  cfg_data,
    input  logic         s_tvalid,
    output logic         s_tready,
    // pt0_x, pt0_y, pt1_x, pt1_y, pt2_x, pt2_y, pt3_x, pt3_y, point_budget
    input  logic [199:0] s_tdata,
    // kind
    input  logic         s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // out_x, out_y
    output logic [47:0]  m_tdata,
    output logic         m_tlast
);
    import baf_pkg::*;

    logic [TOL_W-1:0] tol_reg;
    ctrl_cmd_t cmd;
    ctrl_sts_t sts;
    logic signed [CW-1:0] ex, ey;

    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tol_reg <= TOL_W'(65536);
        end else if (cfg_valid) begin
            tol_reg <= cfg_data;
        end
    end

    baf_ctrl #(.MAX_POINTS(MAX_POINTS)) u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .s_tvalid(s_tvalid), .s_tready(s_tready),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tlast(m_tlast),
        .cmd(cmd), .sts(sts)
    );

    baf_datapath #(.MAX_POINTS(MAX_POINTS)) u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd), .sts(sts), .tol(tol_reg),
        .in_kind(s_tuser), .in_pts(s_tdata[191:0]), .in_budget(s_tdata[198:192]),
        .end_x(ex), .end_y(ey)
    );

    assign m_tdata = {ey, ex};

endmodule

/* sim/testbench.sv */
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import baf_pkg::*;

    localparam int MAXP = 64;
    localparam int HOLD_CYCLES = 400;
    localparam int STALL_LIMIT = 20000;
    localparam logic signed [CW-1:0] CMIN = -24'sd8388608;
    localparam logic signed [CW-1:0] CMAX = 24'sd8388607;

    typedef struct {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        bit                   last;
    } vertex_t;

    typedef struct {
        bit                      kind;
        logic [7:0][CW-1:0]      p;
        int                      budget;
        bit                      typed;
        logic signed [CW-1:0]    ex;
        logic signed [CW-1:0]    ey;
    } curve_row_t;

    logic              aclk = 0;
    logic              aresetn = 0;
    logic              cfg_valid = 0;
    logic              cfg_ready;
    logic [TOL_W-1:0]  cfg_data = '0;
    logic              s_tvalid = 0;
    logic              s_tready;
    logic [199:0]      s_tdata = '0;
    logic              s_tuser = 0;
    logic              m_tvalid;
    logic              m_tready = 0;
    logic [47:0]       m_tdata;
    logic              m_tlast;

    vertex_t           vertex_q[$];
    logic [TOL_W-1:0]  tol_sq = 48'd65536;
    int                errors = 0;
    int                s_idle = 0;
    int                r_stall = 0;
    bit                hold_go = 0;
    bit                hold_done = 0;
    int                hold_left = 0;
    int                quiet_cycles = 0;

    bezier_adaptive_flatten_top #(.MAX_POINTS(MAXP)) i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // squared distance from p to segment a-b, clamped to the ends, below tol?
    function automatic bit near_segment(longint px, longint py, longint ax, longint ay,
                                        longint bx, longint by, logic [TOL_W-1:0] tol);
        longint ux, uy, vx, vy, dot, len, det, tl;
        logic [127:0] sq, rhs;
        ux = bx - ax;
        uy = by - ay;
        vx = px - ax;
        vy = py - ay;
        tl = longint'({16'd0, tol});
        dot = ux * vx + uy * vy;
        len = ux * ux + uy * uy;
        if (dot <= 0)
            return (vx * vx + vy * vy) < tl;
        if (dot > len)
            return ((px - bx) * (px - bx) + (py - by) * (py - by)) < tl;
        det = ux * vy - uy * vx;
        if (det < 0)
            det = -det;
        sq = 128'(det) * 128'(det);
        rhs = 128'(tol) * 128'(len);
        return sq < rhs;
    endfunction

    function automatic longint mid(longint a, longint b);
        return (a + b) >>> 1;
    endfunction

    function automatic void flatten_curve(bit cubic, logic [7:0][CW-1:0] p, int budget);
        longint  wp[8];
        longint  lh[8];
        longint  rh[8];
        longint  stk[7][8];
        int      stk_bud[7];
        int      top, bud, endi, cnt;
        bit      flat;
        longint  q0, q1, q2, r0, r1, s;
        vertex_t v;
        for (int i = 0; i < 8; i++)
            wp[i] = longint'($signed(p[i]));
        bud = (budget > MAXP) ? MAXP : budget;
        endi = cubic ? 3 : 2;
        top = 0;
        cnt = 0;
        while (1) begin
            flat = bud < 2;
            if (!flat)
                flat = near_segment(wp[2], wp[3], wp[0], wp[1], wp[2*endi], wp[2*endi+1], tol_sq);
            if (!bud[31] && bud >= 2 && flat && cubic)
                flat = near_segment(wp[4], wp[5], wp[0], wp[1], wp[6], wp[7], tol_sq);
            if (flat) begin
                v.x = CW'(wp[2*endi]);
                v.y = CW'(wp[2*endi+1]);
                cnt++;
                v.last = (top == 0) || (cnt >= MAXP);
                vertex_q.push_back(v);
                if (v.last)
                    break;
                top--;
                wp = stk[top];
                bud = stk_bud[top];
            end else begin
                lh = '{default: 0};
                rh = '{default: 0};
                for (int c = 0; c < 2; c++) begin
                    q0 = mid(wp[c], wp[2+c]);
                    q1 = mid(wp[2+c], wp[4+c]);
                    if (cubic) begin
                        q2 = mid(wp[4+c], wp[6+c]);
                        r0 = mid(q0, q1);
                        r1 = mid(q1, q2);
                        s = mid(r0, r1);
                        lh[c] = wp[c]; lh[2+c] = q0; lh[4+c] = r0; lh[6+c] = s;
                        rh[c] = s; rh[2+c] = r1; rh[4+c] = q2; rh[6+c] = wp[6+c];
                    end else begin
                        r0 = mid(q0, q1);
                        lh[c] = wp[c]; lh[2+c] = q0; lh[4+c] = r0;
                        rh[c] = r0; rh[2+c] = q1; rh[4+c] = wp[4+c];
                    end
                end
                bud = bud >> 1;
                stk[top] = rh;
                stk_bud[top] = bud;
                top++;
                wp = lh;
            end
        end
    endfunction

    task automatic write_tolerance(logic [TOL_W-1:0] value);
        cfg_valid <= 1;
        cfg_data <= value;
        do @(posedge aclk); while (!cfg_ready);
        tol_sq = value;
        cfg_valid <= 0;
    endtask

    task automatic send_curve(curve_row_t row);
        vertex_t v;
        while ($urandom_range(99) < s_idle) begin
            s_tvalid <= 0;
            @(posedge aclk);
        end
        s_tvalid <= 1;
        s_tdata <= {1'b0, 7'(row.budget), row.p};
        s_tuser <= row.kind;
        do @(posedge aclk); while (!s_tready);
        if (row.typed) begin
            v.x = row.ex;
            v.y = row.ey;
            v.last = 1;
            vertex_q.push_back(v);
        end else begin
            flatten_curve(row.kind, row.p, row.budget);
        end
    endtask

    task automatic drain(int settle);
        s_tvalid <= 0;
        while (vertex_q.size() != 0)
            @(posedge aclk);
        repeat (settle) @(posedge aclk);
    endtask

    function automatic logic [CW-1:0] rand_coord(longint centre, int span);
        longint c;
        c = centre + longint'($urandom_range(2 * span)) - span;
        if (c > CMAX)
            c = CMAX;
        if (c < CMIN)
            c = CMIN;
        return CW'(c);
    endfunction

    function automatic curve_row_t random_curve();
        curve_row_t row;
        longint     centre;
        int         span, pick;
        row.kind = $urandom_range(1);
        row.typed = 0;
        pick = $urandom_range(9);
        centre = longint'($signed(CW'($urandom))) / 2;
        span = 1 << $urandom_range(4, 18);
        for (int i = 0; i < 8; i++)
            row.p[i] = (pick < 2) ? CW'($urandom) : rand_coord(centre, span);
        pick = $urandom_range(99);
        if (pick < 80)
            row.budget = $urandom_range(16);
        else if (pick < 95)
            row.budget = $urandom_range(64);
        else
            row.budget = $urandom_range(127, 65);
        return row;
    endfunction

    function automatic curve_row_t mk(bit kind, longint x0, longint y0, longint x1, longint y1,
                                      longint x2, longint y2, longint x3, longint y3,
                                      int budget, bit typed);
        curve_row_t row;
        row.kind = kind;
        row.p = {CW'(y3), CW'(x3), CW'(y2), CW'(x2), CW'(y1), CW'(x1), CW'(y0), CW'(x0)};
        row.budget = budget;
        row.typed = typed;
        row.ex = kind ? CW'(x3) : CW'(x2);
        row.ey = kind ? CW'(y3) : CW'(y2);
        return row;
    endfunction

    // receiver: checks vertices, random stalls and one long hold-off
    always @(posedge aclk) begin
        vertex_t e;
        if (m_tvalid && m_tready) begin
            if (vertex_q.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected vertex x=%0d y=%0d last=%0b",
                             $signed(m_tdata[23:0]), $signed(m_tdata[47:24]), m_tlast);
            end else begin
                e = vertex_q.pop_front();
                if (m_tdata[23:0] !== e.x || m_tdata[47:24] !== e.y || m_tlast !== e.last) begin
                    errors++;
                    if (errors <= 10)
                        $display("vertex mismatch: exp x=%0d y=%0d last=%0b, got x=%0d y=%0d last=%0b",
                                 e.x, e.y, e.last, $signed(m_tdata[23:0]),
                                 $signed(m_tdata[47:24]), m_tlast);
                end
            end
        end
        if (!aresetn) begin
            m_tready <= 0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_tready <= 0;
        end else if (hold_go && !hold_done) begin
            hold_done <= 1;
            hold_left <= HOLD_CYCLES;
            m_tready <= 0;
        end else begin
            m_tready <= ($urandom_range(99) >= r_stall);
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        curve_row_t         rows[$];
        logic [TOL_W-1:0]   tol_list[6];
        int                 idle_s[4];
        int                 idle_r[4];

        tol_list = '{48'd0, 48'hFFFF_FFFF_FFFF, 48'd65536, 48'd16, 48'd1 << 30, 48'd4096};
        idle_s = '{0, 50, 0, 9};
        idle_r = '{0, 0, 50, 9};

        // budget below 2: end point only; then extremes with large budgets
        rows.push_back(mk(0, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, 0, 1));
        rows.push_back(mk(1, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, 1, 1));
        rows.push_back(mk(0, 0, 0, CMIN, CMAX, CMAX, CMIN, 123, -77, 0, 1));
        rows.push_back(mk(1, CMAX, CMIN, 0, 0, 5, -5, CMIN, CMAX, 0, 1));
        rows.push_back(mk(1, CMIN, CMIN, CMAX, CMIN, CMIN, CMAX, CMAX, CMAX, 127, 0));
        rows.push_back(mk(0, CMIN, CMAX, CMAX, CMAX, CMAX, CMIN, 0, 0, 64, 0));
        rows.push_back(mk(0, CMAX, CMIN, CMIN, CMAX, CMIN, CMAX, 0, 0, 65, 0));
        // degenerate segment
        rows.push_back(mk(0, 100, 100, 100, 100, 100, 100, 0, 0, 2, 0));
        rows.push_back(mk(1, 500, -500, 9000, 4000, 500, -500, 500, -500, 16, 0));
        // controls beyond the ends
        rows.push_back(mk(1, 0, 0, 4000, 0, -2000, 0, 1000, 0, 16, 0));
        rows.push_back(mk(0, 0, 0, -3000, 10, 1000, 0, 0, 0, 8, 0));
        rows.push_back(mk(1, 0, 0, 20000, 20000, -20000, 20000, 0, 0, 32, 0));
        rows.push_back(mk(1, -1, -1, 1, -3, -3, 1, 1, 1, 3, 0));
        rows.push_back(mk(0, 0, 0, 256, 1, 512, 0, 0, 0, 4, 0));
        rows.push_back(mk(0, -7, 3, -9, 40000, 11, -5, 0, 0, 2, 0));

        repeat (4) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        foreach (rows[i])
            send_curve(rows[i]);
        drain(30);

        for (int ph = 0; ph < 6; ph++) begin
            s_idle = idle_s[ph % 4];
            r_stall = idle_r[ph % 4];
            write_tolerance(ph == 5 ? 48'($urandom) << $urandom_range(16) : tol_list[ph]);
            if (ph == 2)
                hold_go = 1;
            for (int n = 0; n < 75; n++)
                send_curve(random_curve());
            drain(30);
        end

        if (errors == 0 && vertex_q.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
